>>> design/bwram_bitmap_projection_port_macros.svh
// Assertion macros for the backup RAM port.
`ifndef BWRAM_BITMAP_PROJECTION_PORT_MACROS_SVH
`define BWRAM_BITMAP_PROJECTION_PORT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BWBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BWBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bwbp_pkg.sv
// Shared types and constants for the backup RAM port.
`default_nettype none

package bwbp_pkg;

    // access direction
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // view codes; code 3 is unused (reads zero, writes dropped)
    localparam logic [1:0] VIEW_WINDOW = 2'd0;
    localparam logic [1:0] VIEW_BITMAP = 2'd1;
    localparam logic [1:0] VIEW_LINEAR = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_BPP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_BITMAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_BANK   = 2'd2;

    localparam int unsigned BANK_W    = 7;
    localparam int unsigned LIN_BANK_W = 5;
    localparam int unsigned WIN_OFF_W = 13;
    localparam int unsigned OFFSET_W  = 20;
    localparam int unsigned DATA_W    = 8;

    localparam logic [DATA_W-1:0] PIX4_MASK = 8'h0f;
    localparam logic [DATA_W-1:0] PIX2_MASK = 8'h03;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_ZERO_RD,
        KIND_BYTE_RD,
        KIND_BYTE_WR,
        KIND_PIX_RD,
        KIND_PIX_WR
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MODIFY
    } t_state;

    typedef struct packed {
        logic capture;    // latch request for the read or modify state
        logic write_now;  // byte write straight from the inputs
        logic writeback;  // merged pixel byte goes back to RAM
    } t_cmd;

endpackage

`default_nettype wire

>>> design/bwbp_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module bwbp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 262144
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/bwbp_ctrl.sv
// Access sequencer: byte-write, read and pixel read-modify-write access flows.
`default_nettype none

module bwbp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire bwbp_pkg::t_kind i_kind,
    output bwbp_pkg::t_cmd      o_cmd,
    output logic                o_busy,
    output logic                o_valid
);

    bwbp_pkg::t_state r_state;
    bwbp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bwbp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bwbp_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (i_kind) inside
                        bwbp_pkg::KIND_ZERO_RD, bwbp_pkg::KIND_BYTE_RD,
                        bwbp_pkg::KIND_PIX_RD: n_state = bwbp_pkg::S_READ;
                        bwbp_pkg::KIND_PIX_WR: n_state = bwbp_pkg::S_MODIFY;
                        default:               n_state = bwbp_pkg::S_IDLE;
                    endcase
                end
            end
            bwbp_pkg::S_READ:   n_state = bwbp_pkg::S_IDLE;
            bwbp_pkg::S_MODIFY: n_state = bwbp_pkg::S_IDLE;
            default:            n_state = bwbp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_busy  = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            bwbp_pkg::S_IDLE: begin
                o_cmd.capture   = i_start;
                o_cmd.write_now = i_start && (i_kind == bwbp_pkg::KIND_BYTE_WR);
            end
            bwbp_pkg::S_READ: begin
                o_busy  = 1'b1;
                o_valid = 1'b1;
            end
            bwbp_pkg::S_MODIFY: begin
                o_busy          = 1'b1;
                o_cmd.writeback = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/bwbp_dp.sv
// Datapath: config registers, address mapping, pixel extract/merge, RAM.
`default_nettype none

module bwbp_dp #(
    parameter int unsigned RAM_BYTES = 262144
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bwbp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [bwbp_pkg::BANK_W-1:0]         i_cfg_wdata,
    input  wire logic                                i_action,
    input  wire logic [1:0]                          i_view,
    input  wire logic [bwbp_pkg::OFFSET_W-1:0]       i_offset,
    input  wire logic [bwbp_pkg::DATA_W-1:0]         i_write_data,
    input  wire bwbp_pkg::t_cmd                      i_cmd,
    output bwbp_pkg::t_kind                          o_kind,
    output logic      [bwbp_pkg::DATA_W-1:0]         o_read_data
);

    localparam int unsigned ADDR_W = $clog2(RAM_BYTES);

    // configuration
    logic                          r_two_bpp;
    logic                          r_win_bitmap;
    logic [bwbp_pkg::BANK_W-1:0]   r_win_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_bpp    <= 1'b0;
            r_win_bitmap <= 1'b0;
            r_win_bank   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bwbp_pkg::CFG_TWO_BPP:    r_two_bpp    <= i_cfg_wdata[0];
                bwbp_pkg::CFG_WIN_BITMAP: r_win_bitmap <= i_cfg_wdata[0];
                bwbp_pkg::CFG_WIN_BANK:   r_win_bank   <= i_cfg_wdata;
                default:                  r_two_bpp    <= r_two_bpp;
            endcase
        end
    end

    // request decode and address mapping
    logic                              is_bitmap;
    logic [bwbp_pkg::OFFSET_W-1:0]     pix;
    logic [bwbp_pkg::OFFSET_W-1:0]     lin_win;
    logic [bwbp_pkg::OFFSET_W-1:0]     pix_byte;
    logic [ADDR_W-1:0]                 in_addr;
    logic [2:0]                        in_shift;
    bwbp_pkg::t_kind                   kind;

    always_comb begin
        is_bitmap = 1'b0;
        pix       = i_offset;
        kind      = bwbp_pkg::KIND_NOP;
        lin_win   = {2'b00, r_win_bank[bwbp_pkg::LIN_BANK_W-1:0],
                     i_offset[bwbp_pkg::WIN_OFF_W-1:0]};
        unique case (i_view)
            bwbp_pkg::VIEW_WINDOW: begin
                is_bitmap = r_win_bitmap;
                pix       = {r_win_bank, i_offset[bwbp_pkg::WIN_OFF_W-1:0]};
            end
            bwbp_pkg::VIEW_BITMAP: is_bitmap = 1'b1;
            bwbp_pkg::VIEW_LINEAR: is_bitmap = 1'b0;
            default:               is_bitmap = 1'b0;
        endcase

        pix_byte = r_two_bpp ? {2'b00, pix[bwbp_pkg::OFFSET_W-1:2]}
                             : {1'b0, pix[bwbp_pkg::OFFSET_W-1:1]};
        in_shift = r_two_bpp ? {pix[1:0], 1'b0} : {pix[0], 2'b00};

        if (is_bitmap) begin
            in_addr = pix_byte[ADDR_W-1:0];
        end else if (i_view == bwbp_pkg::VIEW_WINDOW) begin
            in_addr = lin_win[ADDR_W-1:0];
        end else begin
            in_addr = i_offset[ADDR_W-1:0];
        end

        if (i_view == bwbp_pkg::VIEW_WINDOW || i_view == bwbp_pkg::VIEW_BITMAP
                || i_view == bwbp_pkg::VIEW_LINEAR) begin
            if (i_action == bwbp_pkg::ACT_WRITE) begin
                kind = is_bitmap ? bwbp_pkg::KIND_PIX_WR : bwbp_pkg::KIND_BYTE_WR;
            end else begin
                kind = is_bitmap ? bwbp_pkg::KIND_PIX_RD : bwbp_pkg::KIND_BYTE_RD;
            end
        end else if (i_action == bwbp_pkg::ACT_READ) begin
            kind = bwbp_pkg::KIND_ZERO_RD;
        end
    end

    assign o_kind = kind;

    // request held for the read or modify state
    logic [ADDR_W-1:0]             r_addr;
    logic [2:0]                    r_shift;
    logic                          r_pix2;
    logic                          r_bitmap;
    logic                          r_zero;
    logic [bwbp_pkg::DATA_W-1:0]   r_wdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr   <= in_addr;
            r_shift  <= in_shift;
            r_pix2   <= r_two_bpp;
            r_bitmap <= is_bitmap;
            r_zero   <= (kind == bwbp_pkg::KIND_ZERO_RD);
            r_wdata  <= i_write_data;
        end
    end

    // pixel extract and merge on the byte read back
    logic [bwbp_pkg::DATA_W-1:0] ram_rdata;
    logic [bwbp_pkg::DATA_W-1:0] pmask;
    logic [bwbp_pkg::DATA_W-1:0] field_mask;
    logic [bwbp_pkg::DATA_W-1:0] pixel;
    logic [bwbp_pkg::DATA_W-1:0] merged;

    always_comb begin
        pmask      = r_pix2 ? bwbp_pkg::PIX2_MASK : bwbp_pkg::PIX4_MASK;
        field_mask = pmask << r_shift;
        pixel      = (ram_rdata >> r_shift) & pmask;
        merged     = (ram_rdata & ~field_mask) | (((r_wdata & pmask) << r_shift) & field_mask);
        if (r_zero) begin
            o_read_data = '0;
        end else if (r_bitmap) begin
            o_read_data = pixel;
        end else begin
            o_read_data = ram_rdata;
        end
    end

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_addr;
    logic [bwbp_pkg::DATA_W-1:0]   ram_wdata;

    assign ram_we    = i_cmd.write_now || i_cmd.writeback;
    assign ram_addr  = i_cmd.writeback ? r_addr : in_addr;
    assign ram_wdata = i_cmd.writeback ? merged : i_write_data;

    bwbp_ram #(
        .WIDTH (bwbp_pkg::DATA_W),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

>>> design/bwram_bitmap_projection_port.sv
// Backup RAM port with windowed, bitmap and linear views.
//
// Takes one access at a time: start is sampled while busy is low. A byte
// write, or a write through the unused view code, completes at the accept
// edge and busy stays low. A read (byte, pixel or unused view) holds busy
// for one cycle and presents read_data with o_valid in that cycle, the
// cycle right after acceptance; the receiver cannot stall, so it must take
// the byte then. A pixel write is a read-modify-write on the single-port
// RAM: read at the accept edge, merged byte written back in the next
// cycle, busy high for that cycle. The RAM holds no reset contents and
// needs no clearing pass; RAM_BYTES must be a power of two (2048 to
// 1048576).
`default_nettype none

`include "bwram_bitmap_projection_port_macros.svh"

module bwram_bitmap_projection_port #(
    parameter int unsigned RAM_BYTES = 262144
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bwbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bwbp_pkg::BANK_W-1:0]     i_cfg_wdata,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_action,
    input  wire logic [1:0]                      i_view,
    input  wire logic [bwbp_pkg::OFFSET_W-1:0]   i_offset,
    input  wire logic [bwbp_pkg::DATA_W-1:0]     i_write_data,
    output logic                                 o_valid,
    output logic      [bwbp_pkg::DATA_W-1:0]     o_read_data
);

    bwbp_pkg::t_kind kind;
    bwbp_pkg::t_cmd  cmd;

    bwbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (kind),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    bwbp_dp #(
        .RAM_BYTES (RAM_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_action     (i_action),
        .i_view       (i_view),
        .i_offset     (i_offset),
        .i_write_data (i_write_data),
        .i_cmd        (cmd),
        .o_kind       (kind),
        .o_read_data  (o_read_data)
    );

    // a read transfer always yields exactly one strobe, a write none
    `BWBP_ASSERT_NEXT(a_read_gives_result, i_clk, i_rst_n, start && !busy && i_action == bwbp_pkg::ACT_READ, o_valid, "accepted read gave no result")
    `BWBP_ASSERT_NEXT(a_write_no_result, i_clk, i_rst_n, start && !busy && i_action == bwbp_pkg::ACT_WRITE, !o_valid, "write produced a result")
    `BWBP_ASSERT_NOW(a_result_while_busy, i_clk, i_rst_n, o_valid, busy && !cmd.capture && !cmd.writeback, "result outside read cycle")
    `BWBP_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid, "result strobe held two cycles")

endmodule

`default_nettype wire

>>> tb/sv/tb_bwram_bitmap_projection_port.sv
// Self-checking testbench for the three-view backup RAM port.
`timescale 1ns / 1ps

module tb_bwram_bitmap_projection_port;
    import bwbp_pkg::*;

    localparam int ADDR_W         = 18;
    localparam int RAM_BYTES      = 1 << ADDR_W;
    localparam int CLK_PERIOD     = 20;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 152;
    localparam int HOT_DEPTH      = 48;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam logic [1:0] VIEW_UNUSED = 2'd3;

    // Shadow of the RAM and registers, plus the queue of read bytes still owed.
    class bwram_shadow;
        logic                 two_bpp;
        logic                 win_bitmap;
        logic [BANK_W-1:0]    bank;
        logic [DATA_W-1:0]    ram [RAM_BYTES];
        bit                   written [RAM_BYTES];
        logic [DATA_W-1:0]    expected_bytes [$];
        int unsigned          mismatches;
        int unsigned          reads_checked;

        function new();
            two_bpp       = 1'b0;
            win_bitmap    = 1'b0;
            bank          = '0;
            mismatches    = 0;
            reads_checked = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BANK_W-1:0] val);
            case (idx)
                CFG_TWO_BPP:    two_bpp    = val[0];
                CFG_WIN_BITMAP: win_bitmap = val[0];
                CFG_WIN_BANK:   bank       = val;
                default: ;
            endcase
        endfunction

        // RAM byte an access lands on; pixel accesses also give the pixel address.
        function void resolve(input logic [1:0] view, input logic [OFFSET_W-1:0] off,
                              output bit is_pix, output logic [OFFSET_W-1:0] pix,
                              output logic [ADDR_W-1:0] ba);
            is_pix = 1'b0;
            pix    = '0;
            ba     = '0;
            case (view)
                VIEW_WINDOW: begin
                    if (win_bitmap) begin
                        is_pix = 1'b1;
                        pix    = {bank, off[WIN_OFF_W-1:0]};
                    end else begin
                        ba = {bank[LIN_BANK_W-1:0], off[WIN_OFF_W-1:0]};
                    end
                end
                VIEW_BITMAP: begin
                    is_pix = 1'b1;
                    pix    = off;
                end
                VIEW_LINEAR: ba = off[ADDR_W-1:0];
                default: ;
            endcase
            if (is_pix)
                ba = two_bpp ? pix[ADDR_W+1:2] : pix[ADDR_W:1];
        endfunction

        // True when the access would read a byte nobody has written yet.
        function bit needs_prefill(input logic act, input logic [1:0] view,
                                   input logic [OFFSET_W-1:0] off);
            bit                  is_pix;
            logic [OFFSET_W-1:0] pix;
            logic [ADDR_W-1:0]   ba;
            if (view == VIEW_UNUSED)
                return 1'b0;
            resolve(view, off, is_pix, pix, ba);
            return (act == ACT_READ || is_pix) && !written[ba];
        endfunction

        function void note_access(input logic act, input logic [1:0] view,
                                  input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] wd);
            bit                  is_pix;
            logic [OFFSET_W-1:0] pix;
            logic [ADDR_W-1:0]   ba;
            logic [2:0]          sh;
            logic [DATA_W-1:0]   pm;
            logic [DATA_W-1:0]   cur;
            if (view == VIEW_UNUSED) begin
                if (act == ACT_READ)
                    expected_bytes.push_back('0);
                return;
            end
            resolve(view, off, is_pix, pix, ba);
            pm  = two_bpp ? PIX2_MASK : PIX4_MASK;
            sh  = two_bpp ? {pix[1:0], 1'b0} : {pix[0], 2'b00};
            cur = ram[ba];
            if (act == ACT_WRITE) begin
                ram[ba]     = is_pix ? ((cur & ~(pm << sh)) | ((wd & pm) << sh)) : wd;
                written[ba] = 1'b1;
            end else begin
                expected_bytes.push_back(is_pix ? ((cur >> sh) & pm) : cur);
            end
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= 100)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_read(input logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("read_data %02h with no read pending", got));
            end else begin
                want = expected_bytes.pop_front();
                reads_checked++;
                if (got !== want)
                    report_mismatch($sformatf("read_data %02h, expected %02h", got, want));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [BANK_W-1:0]      i_cfg_wdata;
    logic                   start;
    logic                   busy;
    logic                   i_action;
    logic [1:0]             i_view;
    logic [OFFSET_W-1:0]    i_offset;
    logic [DATA_W-1:0]      i_write_data;
    logic                   o_valid;
    logic [DATA_W-1:0]      o_read_data;

    bwram_shadow            board;
    logic [ADDR_W-1:0]      recent_bytes [$];
    int unsigned            accesses_sent;
    int unsigned            settings_applied;

    bwram_bitmap_projection_port #(
        .RAM_BYTES(RAM_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_view      (i_view),
        .i_offset    (i_offset),
        .i_write_data(i_write_data),
        .o_valid     (o_valid),
        .o_read_data (o_read_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0)
            board.check_read(o_read_data);
    end

    // One transfer; enters and leaves at a falling edge.
    task automatic send_access(input logic act, input logic [1:0] view,
                               input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] wd);
        bit                  is_pix;
        logic [OFFSET_W-1:0] pix;
        logic [ADDR_W-1:0]   ba;
        start        = 1'b1;
        i_action     = act;
        i_view       = view;
        i_offset     = off;
        i_write_data = wd;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        board.note_access(act, view, off, wd);
        accesses_sent++;
        if (act == ACT_WRITE && view != VIEW_UNUSED) begin
            board.resolve(view, off, is_pix, pix, ba);
            recent_bytes.push_back(ba);
            if (recent_bytes.size() > HOT_DEPTH)
                void'(recent_bytes.pop_front());
        end
        @(negedge i_clk);
    endtask

    // Reads and pixel writes of unwritten bytes get a linear byte write first.
    task automatic issue(input logic act, input logic [1:0] view,
                         input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] wd);
        bit                  is_pix;
        logic [OFFSET_W-1:0] pix;
        logic [ADDR_W-1:0]   ba;
        logic [OFFSET_W-1:0] fill_off;
        if (board.needs_prefill(act, view, off)) begin
            board.resolve(view, off, is_pix, pix, ba);
            fill_off = OFFSET_W'($urandom);
            fill_off[ADDR_W-1:0] = ba;
            send_access(ACT_WRITE, VIEW_LINEAR, fill_off, DATA_W'($urandom));
        end
        send_access(act, view, off, wd);
    endtask

    task automatic sender_gap(input int unsigned cycles);
        start = 1'b0;
        repeat (cycles) begin
            i_action     = 1'($urandom);
            i_view       = 2'($urandom);
            i_offset     = OFFSET_W'($urandom);
            i_write_data = DATA_W'($urandom);
            @(negedge i_clk);
        end
    endtask

    // Hold off until every read has returned and a pending pixel write is done.
    task automatic drain_reads();
        start = 1'b0;
        while (board.expected_bytes.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BANK_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_IDX_W'($urandom);
        i_cfg_wdata = BANK_W'($urandom);
        board.set_reg(idx, val);
    endtask

    // Upper bits of the one-bit registers carry junk on purpose.
    task automatic apply_setting(input logic bpp, input logic wb, input logic [BANK_W-1:0] bank_sel);
        logic [BANK_W-1:0] v;
        drain_reads();
        v    = BANK_W'($urandom);
        v[0] = bpp;
        write_reg(CFG_TWO_BPP, v);
        v    = BANK_W'($urandom);
        v[0] = wb;
        write_reg(CFG_WIN_BITMAP, v);
        write_reg(CFG_WIN_BANK, bank_sel);
        settings_applied++;
    endtask

    // Pick an offset that lands on RAM byte a; falls back to the linear view
    // when the current window cannot reach it.
    function automatic void aim_at(input logic [ADDR_W-1:0] a, inout logic [1:0] view,
                                   inout logic [OFFSET_W-1:0] off);
        logic [OFFSET_W-1:0] r;
        r = OFFSET_W'($urandom);
        if (view == VIEW_WINDOW) begin
            if (!board.win_bitmap &&
                a[ADDR_W-1:WIN_OFF_W] == board.bank[LIN_BANK_W-1:0]) begin
                off = {r[OFFSET_W-1:WIN_OFF_W], a[WIN_OFF_W-1:0]};
                return;
            end
            if (board.win_bitmap && !board.two_bpp &&
                a[ADDR_W-1:WIN_OFF_W-1] == board.bank[BANK_W-2:0]) begin
                off = {r[OFFSET_W-1:WIN_OFF_W], a[WIN_OFF_W-2:0], r[0]};
                return;
            end
            if (board.win_bitmap && board.two_bpp &&
                a[ADDR_W-1:WIN_OFF_W-2] == board.bank) begin
                off = {r[OFFSET_W-1:WIN_OFF_W], a[WIN_OFF_W-3:0], r[1:0]};
                return;
            end
            view = VIEW_LINEAR;
        end
        case (view)
            VIEW_LINEAR: off = {r[OFFSET_W-1:ADDR_W], a};
            VIEW_BITMAP: off = board.two_bpp ? {a, r[1:0]} : {r[OFFSET_W-1], a, r[0]};
            default: ;
        endcase
    endfunction

    task automatic random_access();
        logic                act;
        logic [1:0]          view;
        logic [OFFSET_W-1:0] off;
        int unsigned         r;
        int unsigned         s;
        act = 1'($urandom_range(0, 1));
        r   = $urandom_range(0, 99);
        if (r < 30)
            view = VIEW_WINDOW;
        else if (r < 60)
            view = VIEW_BITMAP;
        else if (r < 92)
            view = VIEW_LINEAR;
        else
            view = VIEW_UNUSED;
        off = OFFSET_W'($urandom);
        s   = $urandom_range(0, 99);
        if (s < 55 && recent_bytes.size() != 0) begin
            aim_at(recent_bytes[$urandom_range(0, recent_bytes.size() - 1)], view, off);
        end else if (s < 80) begin
            // small corner of the space so different views alias onto the same bytes
            if (view == VIEW_WINDOW)
                off[WIN_OFF_W-1:0] = WIN_OFF_W'($urandom_range(0, 63));
            else
                off = OFFSET_W'($urandom_range(0, 63));
        end
        issue(act, view, off, DATA_W'($urandom));
    endtask

    task automatic directed_accesses();
        // linear extremes, offset above RAM size mirrors down
        issue(ACT_WRITE, VIEW_LINEAR, 20'h00000, 8'h00);
        issue(ACT_READ,  VIEW_LINEAR, 20'h00000, 8'hff);
        issue(ACT_WRITE, VIEW_LINEAR, 20'hfffff, 8'hff);
        issue(ACT_READ,  VIEW_LINEAR, 20'h3ffff, 8'h00);
        // 4-bit pixels into the top byte, back to back, junk above the nibble
        issue(ACT_WRITE, VIEW_BITMAP, 20'h7fffe, 8'hfa);
        issue(ACT_WRITE, VIEW_BITMAP, 20'hfffff, 8'h05);
        issue(ACT_READ,  VIEW_BITMAP, 20'h7fffe, 8'h00);
        issue(ACT_READ,  VIEW_BITMAP, 20'h7ffff, 8'h00);
        issue(ACT_READ,  VIEW_LINEAR, 20'h3ffff, 8'h00);
        // window into linear RAM, bank 0, top of window
        issue(ACT_WRITE, VIEW_WINDOW, 20'hfffff, 8'hc3);
        issue(ACT_READ,  VIEW_LINEAR, 20'h01fff, 8'h00);
        // unused view code: write dropped, read gives zero
        issue(ACT_WRITE, VIEW_UNUSED, 20'h00000, 8'h77);
        issue(ACT_READ,  VIEW_UNUSED, 20'hfffff, 8'hff);
        issue(ACT_READ,  VIEW_LINEAR, 20'h00000, 8'h00);

        // 2-bit pixels, window into bitmap space at the top bank
        apply_setting(1'b1, 1'b1, 7'h7f);
        issue(ACT_WRITE, VIEW_WINDOW, 20'h01fff, 8'hfe);
        issue(ACT_READ,  VIEW_WINDOW, 20'h01fff, 8'h00);
        issue(ACT_READ,  VIEW_BITMAP, 20'hffffc, 8'h00);
        issue(ACT_WRITE, VIEW_BITMAP, 20'h00001, 8'h03);
        issue(ACT_READ,  VIEW_BITMAP, 20'h00001, 8'h00);
        issue(ACT_READ,  VIEW_LINEAR, 20'h00000, 8'h00);

        // linear window uses only the low bank bits
        apply_setting(1'b0, 1'b0, 7'h7f);
        issue(ACT_WRITE, VIEW_WINDOW, 20'h00000, 8'h81);
        issue(ACT_READ,  VIEW_LINEAR, 20'h3e000, 8'h00);
    endtask

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        bit calm;
        board            = new();
        accesses_sent    = 0;
        settings_applied = 0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_wdata      = '0;
        start            = 1'b0;
        i_action         = ACT_READ;
        i_view           = VIEW_LINEAR;
        i_offset         = '0;
        i_write_data     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        apply_setting(1'b0, 1'b0, 7'h00);
        directed_accesses();

        for (int k = 0; k < N_PHASES; k++) begin
            case (k)
                0:       apply_setting(1'b1, 1'b0, 7'h7f);
                1:       apply_setting(1'b0, 1'b1, 7'h7f);
                2:       apply_setting(1'b1, 1'b1, 7'h00);
                3:       apply_setting(1'b0, 1'b0, 7'h1f);
                default: apply_setting(1'($urandom), 1'($urandom), BANK_W'($urandom));
            endcase
            calm = (k == N_PHASES - 1) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_access();
                if (!calm && $urandom_range(0, 4) == 0)
                    sender_gap($urandom_range(1, 12));
                if (!calm && $urandom_range(0, 149) == 0)
                    drain_reads();
            end
        end

        start = 1'b0;
        for (int w = 0; w < 200 && board.expected_bytes.size() != 0; w++)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (board.expected_bytes.size() != 0)
            board.report_mismatch($sformatf("%0d read results never arrived",
                                            board.expected_bytes.size()));

        $display("Sent %0d accesses through all views, %0d read results checked",
                 accesses_sent, board.reads_checked);
        $display("Register settings applied: %0d, both pixel depths and both window targets",
                 settings_applied);
        if (board.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
